/* rtl/qpb64_pkg.sv */
// Shared constants, status codes and character lookup functions for the
// quoted-printable / base64 byte decoder. No dependencies.
package qpb64_pkg;

  localparam int CharW   = 8;
  localparam int StatusW = 2;
  localparam int CountW  = 16;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  typedef logic [CharW-1:0]   char_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CountW-1:0]  count_t;

  localparam status_t ST_BYTE = 2'd0;
  localparam status_t ST_DONE = 2'd1;
  localparam status_t ST_ERR  = 2'd2;

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_ENCODING    = 1'b0;
  localparam logic REG_HEADER_MODE = 1'b1;

  localparam logic ENC_QP  = 1'b0;
  localparam logic ENC_B64 = 1'b1;

  typedef enum logic [1:0] {
    QP_IDLE   = 2'd0,
    QP_EQUALS = 2'd1,
    QP_DIGIT  = 2'd2
  } qp_phase_t;

  localparam char_t CH_CR       = 8'h0d;
  localparam char_t CH_LF       = 8'h0a;
  localparam char_t CH_EQUALS   = 8'h3d;
  localparam char_t CH_QUESTION = 8'h3f;
  localparam char_t CH_UNDER    = 8'h5f;
  localparam char_t CH_SPACE    = 8'h20;
  localparam char_t CH_PLUS     = 8'h2b;
  localparam char_t CH_SLASH    = 8'h2f;
  localparam count_t COUNT_MAX  = 16'hffff;

  // Returns {ok, nibble}.
  function automatic logic [4:0] hex_value(input char_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Returns {ok, six-bit symbol value}.
  function automatic logic [6:0] b64_value(input char_t c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, 6'(c - 8'h47)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c + 8'h04)};
    end else if (c == CH_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (c == CH_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

/* rtl/qpb64_in_if.sv */
// Input channel: one encoded character or end-of-text marker per beat.
// Depends on qpb64_pkg.
interface qpb64_in_if;
  logic                  valid;
  logic                  ready;
  qpb64_pkg::char_t      char_in;
  logic                  end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

/* rtl/qpb64_out_if.sv */
// Result channel: decoded byte, finish or error status per beat.
// Depends on qpb64_pkg.
interface qpb64_out_if;
  logic                  valid;
  logic                  ready;
  qpb64_pkg::char_t      byte_out;
  qpb64_pkg::status_t    status;
  qpb64_pkg::count_t     byte_count;

  modport source (output valid, output byte_out, output status, output byte_count,
                  input ready);
  modport sink   (input valid, input byte_out, input status, input byte_count,
                  output ready);
endinterface

/* rtl/qp_base64_byte_decoder_core.sv */
// Top level of the quoted-printable / base64 byte decoder.
// Depends on qpb64_pkg, qpb64_in_if and qpb64_out_if.

// The decoder takes one character beat per cycle and gives at most one
// result beat per character, from a single registered output; a character
// is taken whenever that register is empty or is being read in the same
// cycle, so while results are read it takes one character per clock.
// Status 0 carries a decoded byte, status 1 marks a finished string with
// its saturating byte count, status 2 a malformed escape.
// The encoding and header_mode registers sit at byte addresses 0 and 4 and
// should be written only while no string is in flight.
module qp_base64_byte_decoder_core (
  input  logic                      clk,
  input  logic                      rst_n,
  qpb64_in_if.sink                  in_chan,
  qpb64_out_if.source               out_chan,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [qpb64_pkg::CfgAddrW-1:0] paddr,
  input  logic [qpb64_pkg::CfgDataW-1:0] pwdata,
  output logic [qpb64_pkg::CfgDataW-1:0] prdata,
  output logic                      pready
);
  import qpb64_pkg::*;

  logic       encoding_r;
  logic       header_mode_r;

  qp_phase_t  qp_phase_r,      qp_phase_nxt;
  logic [3:0] first_nibble_r,  first_nibble_nxt;
  logic [11:0] bit_window_r,   bit_window_nxt;
  logic [2:0] window_bits_r,   window_bits_nxt;
  count_t     decoded_count_r, decoded_count_nxt;
  logic       discarding_r,    discarding_nxt;

  logic       out_valid_r,     out_valid_nxt;
  char_t      out_byte_r,      out_byte_nxt;
  status_t    out_status_r,    out_status_nxt;
  count_t     out_count_r,     out_count_nxt;

  logic       in_fire;
  logic       cfg_write;
  char_t      c;
  logic [4:0] hex;
  logic [6:0] b64;
  logic [3:0] wb_sum;
  logic [3:0] wb_left;
  logic [11:0] win_shift;
  count_t     count_inc;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_HEADER_MODE) ? {{(CfgDataW-1){1'b0}}, header_mode_r}
                                                   : {{(CfgDataW-1){1'b0}}, encoding_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encoding_r    <= ENC_QP;
      header_mode_r <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_HEADER_MODE) begin
        header_mode_r <= pwdata[0];
      end else begin
        encoding_r <= pwdata[0];
      end
    end
  end

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign c         = in_chan.char_in;
  assign hex       = hex_value(c);
  assign b64       = b64_value(c);
  assign wb_sum    = {1'b0, window_bits_r} + 4'd6;
  assign wb_left   = wb_sum - 4'd8;
  assign win_shift = {bit_window_r[5:0], b64[5:0]};
  assign count_inc = (decoded_count_r != COUNT_MAX) ? decoded_count_r + 16'd1
                                                    : decoded_count_r;

  always_comb begin
    qp_phase_nxt      = qp_phase_r;
    first_nibble_nxt  = first_nibble_r;
    bit_window_nxt    = bit_window_r;
    window_bits_nxt   = window_bits_r;
    decoded_count_nxt = decoded_count_r;
    discarding_nxt    = discarding_r;

    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    if (in_fire) begin
      out_valid_nxt  = 1'b0;
      out_byte_nxt   = '0;
      out_status_nxt = ST_BYTE;
      out_count_nxt  = '0;

      if (in_chan.end_of_text) begin
        qp_phase_nxt      = QP_IDLE;
        first_nibble_nxt  = '0;
        bit_window_nxt    = '0;
        window_bits_nxt   = '0;
        decoded_count_nxt = '0;
        discarding_nxt    = 1'b0;
        if (!discarding_r) begin
          out_valid_nxt = 1'b1;
          if (encoding_r == ENC_QP && qp_phase_r != QP_IDLE) begin
            out_status_nxt = ST_ERR;
          end else begin
            out_status_nxt = ST_DONE;
            out_count_nxt  = decoded_count_r;
          end
        end
      end else if (!discarding_r) begin
        if (encoding_r == ENC_QP) begin
          unique case (qp_phase_r)
            QP_EQUALS: begin
              if (c == CH_CR || c == CH_LF) begin
                qp_phase_nxt = QP_IDLE;
              end else if (!hex[4]) begin
                qp_phase_nxt   = QP_IDLE;
                discarding_nxt = 1'b1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_ERR;
              end else begin
                first_nibble_nxt = hex[3:0];
                qp_phase_nxt     = QP_DIGIT;
              end
            end
            QP_DIGIT: begin
              qp_phase_nxt  = QP_IDLE;
              out_valid_nxt = 1'b1;
              if (!hex[4]) begin
                discarding_nxt = 1'b1;
                out_status_nxt = ST_ERR;
              end else begin
                out_byte_nxt      = {first_nibble_r, hex[3:0]};
                decoded_count_nxt = count_inc;
              end
            end
            QP_IDLE: begin
              if (header_mode_r && c == CH_QUESTION) begin
                discarding_nxt = 1'b1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_DONE;
                out_count_nxt  = decoded_count_r;
              end else if (c == CH_EQUALS) begin
                qp_phase_nxt = QP_EQUALS;
              end else begin
                out_valid_nxt     = 1'b1;
                out_byte_nxt      = (header_mode_r && c == CH_UNDER) ? CH_SPACE : c;
                decoded_count_nxt = count_inc;
              end
            end
            default: begin
              qp_phase_nxt = QP_IDLE;
            end
          endcase
        end else begin
          if (header_mode_r && c == CH_QUESTION) begin
            discarding_nxt = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_DONE;
            out_count_nxt  = decoded_count_r;
          end else if (b64[6]) begin
            bit_window_nxt = win_shift;
            if (wb_sum >= 4'd8) begin
              // At most 12 bits are pending; the byte sits just above the leftover bits.
              window_bits_nxt   = wb_left[2:0];
              out_valid_nxt     = 1'b1;
              out_byte_nxt      = 8'(win_shift >> wb_left);
              decoded_count_nxt = count_inc;
            end else begin
              window_bits_nxt = wb_sum[2:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qp_phase_r      <= QP_IDLE;
      first_nibble_r  <= '0;
      bit_window_r    <= '0;
      window_bits_r   <= '0;
      decoded_count_r <= '0;
      discarding_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      qp_phase_r      <= qp_phase_nxt;
      first_nibble_r  <= first_nibble_nxt;
      bit_window_r    <= bit_window_nxt;
      window_bits_r   <= window_bits_nxt;
      decoded_count_r <= decoded_count_nxt;
      discarding_r    <= discarding_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.byte_out   = out_byte_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.byte_count = out_count_r;

`ifndef NO_ASSERTIONS
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_BYTE || out_status_r == ST_DONE ||
                     out_status_r == ST_ERR))
    else $error("result beat carries an undefined status");

  a_byte_zero_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_BYTE) |-> (out_byte_r == '0))
    else $error("finish or error beat carries a nonzero byte");

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    window_bits_r <= 3'd6)
    else $error("base64 pending bit count out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.end_of_text) |=>
      (decoded_count_r == '0 && !discarding_r && qp_phase_r == QP_IDLE &&
       window_bits_r == '0))
    else $error("end of text did not return string state to reset");
`endif

endmodule
